FILE: rtl/cpfa_pkg.sv
// Shared types and constants for the cutoff pair force accumulator.
// No dependencies; used by cutoff_pair_force_accumulator.
package cpfa_pkg;

    localparam int unsigned POS_W  = 48;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned MUL_W  = 192;
    localparam int unsigned DIV_W  = 256;
    localparam int unsigned SQ_W   = 97;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 64;

    localparam logic [POS_W-1:0] CUTOFF_RESET = 48'd42949673;
    localparam logic [POS_W-1:0] MINRAD_RESET = 48'd429497;
    localparam logic [POS_W-1:0] MASS_RESET   = 48'd42949673;

    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_MINRAD = 2'd1;
    localparam logic [1:0] REG_MASS   = 2'd2;

    localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST,
        ST_SQRT,
        ST_DIV,
        ST_TERM,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_DX2,
        OP_DY2,
        OP_C2,
        OP_M2,
        OP_RS,
        OP_RSM,
        OP_NX,
        OP_NY
    } op_t;

endpackage

FILE: rtl/cutoff_pair_force_accumulator.sv
// Cutoff pair force accumulator, top level.
// Depends on cpfa_pkg.
//
// Input stream: one particle-neighbor pair per request. s_tdata carries own and
// neighbor positions, s_tuser marks the first pair of a run (clears the sums),
// s_tlast marks the last pair (emits the sums on the m_ channel afterwards).
// Configuration goes through the APB port: cutoff at 0x00, min radius at 0x08,
// mass at 0x10, 48 bits each; pready is always high.
// One sequencer drives a shift-add multiplier, a digit-by-digit square root and
// a restoring divider, one bit per cycle each. A pair runs eight 48-step
// multiplies, a 48-step square root and two 64-step divisions; a pair that lies
// beyond the cutoff or has a zero denominator ends early, and a saturated
// quotient skips its division.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register: the next pair is taken while it waits.
// If a new result is due while the old one is still stalled, the sequencer
// holds at its final step until m_tready frees the register.
// Reset restores the register defaults and clears the sums and all valids.
module cutoff_pair_force_accumulator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // own_x [47:0], own_y [95:48], nbr_x [143:96], nbr_y [191:144]
    input  logic [191:0]                s_tdata,
    // first_pair
    input  logic                        s_tuser,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // accel_x [63:0], accel_y [127:64]
    output logic [127:0]                m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpfa_pkg::ADDR_W-1:0] paddr,
    input  logic [cpfa_pkg::DATA_W-1:0] pwdata,
    output logic [cpfa_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import cpfa_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [POS_W-1:0] cutoff_reg, minrad_reg, mass_reg;
    logic [POS_W-1:0] dxm_reg, dym_reg, rcm_reg;
    logic             negx_reg, negy_reg, negrc_reg, last_reg, sat_reg;
    logic [95:0]      sx_reg;
    logic [SQ_W-1:0]  s_reg, sq_x_reg, sq_res_reg;
    logic [95:0]      sq_bit_reg;
    logic [MUL_W-1:0] mul_a_reg, mul_acc_reg, den_reg;
    logic [POS_W-1:0] mul_b_reg;
    logic [6:0]       cnt_reg;
    logic [DIV_W-1:0] rem_reg, dsh_reg;
    logic [ACC_W-1:0] q_reg;
    logic [ACC_W-1:0] sum_ax_reg, sum_ay_reg;
    logic             m_valid_reg;
    logic [127:0]     m_data_reg;

    logic [POS_W-1:0] own_x, own_y, nbr_x, nbr_y;
    logic             cfg_we, in_acc, out_free;
    logic [SQ_W-1:0]  acc97, sq_t, sq_x_n, sq_res_n;
    logic             sq_ge, c2_skip, den_zero, div_sat, div_ge, neg_term, ovf;
    logic [DIV_W-1:0] num_w;
    logic [ACC_W-1:0] term_w, sum_sel, sum_res;
    logic [ACC_W:0]   sum65;

    assign own_x = s_tdata[47:0];
    assign own_y = s_tdata[95:48];
    assign nbr_x = s_tdata[143:96];
    assign nbr_y = s_tdata[191:144];

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        case (paddr[4:3])
            REG_CUTOFF: prdata = {16'd0, cutoff_reg};
            REG_MINRAD: prdata = {16'd0, minrad_reg};
            REG_MASS:   prdata = {16'd0, mass_reg};
            default:    prdata = '0;
        endcase
    end

    assign acc97    = mul_acc_reg[SQ_W-1:0];
    assign c2_skip  = s_reg > acc97;
    assign den_zero = (mul_acc_reg == '0);
    assign num_w    = {64'd0, mul_acc_reg} << 88;
    assign div_sat  = num_w >= {den_reg, 64'd0};
    assign div_ge   = rem_reg >= dsh_reg;

    assign sq_t  = sq_res_reg + {1'b0, sq_bit_reg};
    assign sq_ge = sq_x_reg >= sq_t;
    always_comb begin
        if (sq_ge) begin
            sq_x_n   = sq_x_reg - sq_t;
            sq_res_n = (sq_res_reg >> 1) + {1'b0, sq_bit_reg};
        end else begin
            sq_x_n   = sq_x_reg;
            sq_res_n = sq_res_reg >> 1;
        end
    end

    assign neg_term = negrc_reg ^ ((op_reg == OP_NX) ? negx_reg : negy_reg);
    always_comb begin
        if (sat_reg || q_reg[ACC_W-1]) begin
            term_w = neg_term ? SAT_MIN : SAT_MAX;
        end else begin
            term_w = neg_term ? (~q_reg + 64'd1) : q_reg;
        end
    end
    assign sum_sel = (op_reg == OP_NX) ? sum_ax_reg : sum_ay_reg;
    assign sum65   = {sum_sel[ACC_W-1], sum_sel} + {term_w[ACC_W-1], term_w};
    assign ovf     = sum65[ACC_W] != sum65[ACC_W-1];
    assign sum_res = ovf ? (sum65[ACC_W] ? SAT_MIN : SAT_MAX) : sum65[ACC_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == 7'd47) state_next = ST_POST;
            ST_POST: begin
                unique case (op_reg)
                    OP_C2:  state_next = c2_skip ? ST_FIN : ST_MUL;
                    OP_M2:  state_next = ST_SQRT;
                    OP_RSM: state_next = den_zero ? ST_FIN : ST_MUL;
                    OP_NX, OP_NY: state_next = div_sat ? ST_TERM : ST_DIV;
                    default: state_next = ST_MUL;
                endcase
            end
            ST_SQRT: if (cnt_reg == 7'd47) state_next = ST_MUL;
            ST_DIV:  if (cnt_reg == 7'd63) state_next = ST_TERM;
            ST_TERM: state_next = (op_reg == OP_NX) ? ST_MUL : ST_FIN;
            ST_FIN:  if (!last_reg || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DX2;
            cutoff_reg  <= CUTOFF_RESET;
            minrad_reg  <= MINRAD_RESET;
            mass_reg    <= MASS_RESET;
            sum_ax_reg  <= '0;
            sum_ay_reg  <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (paddr[4:3])
                    REG_CUTOFF: cutoff_reg <= pwdata[POS_W-1:0];
                    REG_MINRAD: minrad_reg <= pwdata[POS_W-1:0];
                    REG_MASS:   mass_reg   <= pwdata[POS_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_FIN && last_reg && out_free) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        dxm_reg  <= (nbr_x >= own_x) ? nbr_x - own_x : own_x - nbr_x;
                        dym_reg  <= (nbr_y >= own_y) ? nbr_y - own_y : own_y - nbr_y;
                        negx_reg <= nbr_x < own_x;
                        negy_reg <= nbr_y < own_y;
                        last_reg <= s_tlast;
                        if (s_tuser) begin
                            sum_ax_reg <= '0;
                            sum_ay_reg <= '0;
                        end
                        op_reg      <= OP_DX2;
                        mul_a_reg   <= {144'd0, ((nbr_x >= own_x) ? nbr_x - own_x
                                                              : own_x - nbr_x)};
                        mul_b_reg   <= (nbr_x >= own_x) ? nbr_x - own_x : own_x - nbr_x;
                        mul_acc_reg <= '0;
                        cnt_reg     <= '0;
                    end
                end
                ST_MUL: begin
                    if (mul_b_reg[0]) mul_acc_reg <= mul_acc_reg + mul_a_reg;
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                    cnt_reg   <= cnt_reg + 7'd1;
                end
                ST_POST: begin
                    cnt_reg     <= '0;
                    mul_acc_reg <= '0;
                    unique case (op_reg)
                        OP_DX2: begin
                            sx_reg    <= mul_acc_reg[95:0];
                            op_reg    <= OP_DY2;
                            mul_a_reg <= {144'd0, dym_reg};
                            mul_b_reg <= dym_reg;
                        end
                        OP_DY2: begin
                            s_reg     <= {1'b0, sx_reg} + {1'b0, mul_acc_reg[95:0]};
                            op_reg    <= OP_C2;
                            mul_a_reg <= {144'd0, cutoff_reg};
                            mul_b_reg <= cutoff_reg;
                        end
                        OP_C2: begin
                            op_reg    <= OP_M2;
                            mul_a_reg <= {144'd0, minrad_reg};
                            mul_b_reg <= minrad_reg;
                        end
                        OP_M2: begin
                            if (s_reg < acc97) begin
                                s_reg    <= acc97;
                                sq_x_reg <= acc97;
                            end else begin
                                sq_x_reg <= s_reg;
                            end
                            sq_res_reg <= '0;
                            sq_bit_reg <= 96'd1 << 94;
                        end
                        OP_RS: begin
                            op_reg    <= OP_RSM;
                            mul_a_reg <= mul_acc_reg;
                            mul_b_reg <= mass_reg;
                        end
                        OP_RSM: begin
                            den_reg   <= mul_acc_reg;
                            op_reg    <= OP_NX;
                            mul_a_reg <= {144'd0, rcm_reg};
                            mul_b_reg <= dxm_reg;
                        end
                        default: begin
                            rem_reg <= num_w;
                            dsh_reg <= {1'b0, den_reg, 63'd0};
                            sat_reg <= div_sat;
                            q_reg   <= '0;
                        end
                    endcase
                end
                ST_SQRT: begin
                    sq_x_reg   <= sq_x_n;
                    sq_res_reg <= sq_res_n;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (cnt_reg == 7'd47) begin
                        negrc_reg   <= sq_res_n[POS_W-1:0] < cutoff_reg;
                        rcm_reg     <= (sq_res_n[POS_W-1:0] < cutoff_reg)
                                       ? cutoff_reg - sq_res_n[POS_W-1:0]
                                       : sq_res_n[POS_W-1:0] - cutoff_reg;
                        op_reg      <= OP_RS;
                        mul_a_reg   <= {95'd0, s_reg};
                        mul_b_reg   <= sq_res_n[POS_W-1:0];
                        mul_acc_reg <= '0;
                        cnt_reg     <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ST_DIV: begin
                    if (div_ge) rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[ACC_W-2:0], div_ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_TERM: begin
                    if (op_reg == OP_NX) begin
                        sum_ax_reg  <= sum_res;
                        op_reg      <= OP_NY;
                        mul_a_reg   <= {144'd0, rcm_reg};
                        mul_b_reg   <= dym_reg;
                        mul_acc_reg <= '0;
                        cnt_reg     <= '0;
                    end else begin
                        sum_ay_reg <= sum_res;
                    end
                end
                ST_FIN: begin
                    if (last_reg && out_free) begin
                        m_data_reg <= {sum_ay_reg, sum_ax_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input taken while sequencer busy");

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL || state_reg == ST_SQRT) |-> cnt_reg < 7'd48)
        else $error("multiply or root step count overrun");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg < 7'd64)
        else $error("divide step count overrun");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_data_reg))
        else $error("pending result overwritten");

endmodule
